// ----- rtl/core/svvt_pkg.sv -----
// Shared constants and controller/datapath types for the session version view table.
package svvt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int SESSION_W   = 32;
   localparam int VERSION_W   = 64;
   localparam int ACTIVE_W    = 7;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic load;
      logic match;
      logic read;
      logic write;
   } svvt_cmd_type;

   typedef struct packed {
      logic out_free;
   } svvt_sts_type;

endpackage

// ----- rtl/core/svvt_ctrl.sv -----
// Sequencer for one transaction: accept, match, read, write back.
module svvt_ctrl import svvt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  svvt_sts_type sts,
   output svvt_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MATCH = 4'b0010,
      ST_READ  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/svvt_datapath.sv -----
// Session match array, version memory, entry count and result register.
module svvt_datapath import svvt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  svvt_cmd_type         cmd,
   output svvt_sts_type         sts,
   input  logic                 req_command,
   input  logic [SESSION_W-1:0] req_session_id,
   input  logic [VERSION_W-1:0] req_seen_version,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VERSION_W-1:0] rsp_peak_version,
   output logic                 rsp_hit,
   output logic                 rsp_status,
   output logic [ACTIVE_W-1:0]  rsp_active_sessions
);

   logic                 command_ff;
   logic [SESSION_W-1:0] session_id_ff;
   logic [VERSION_W-1:0] version_ff;

   logic [SESSION_W-1:0] session_ff [TABLE_DEPTH];
   logic [VERSION_W-1:0] highest_mem [TABLE_DEPTH];
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [TABLE_DEPTH-1:0] match;
   logic [INDEX_W-1:0]     index_in, index_ff;
   logic                   hit_ff;
   logic [VERSION_W-1:0]   stored_ff;

   logic                 is_update, raise, append, mem_we;
   logic [INDEX_W-1:0]   wr_addr;
   logic [VERSION_W-1:0] highest_in;

   logic                 rsp_valid_ff;
   logic [VERSION_W-1:0] highest_ff;
   logic                 hit_out_ff, status_ff;
   logic [ACTIVE_W-1:0]  active_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff    <= req_command;
         session_id_ff <= req_session_id;
         version_ff    <= req_seen_version;
      end
   end

   // parallel compare against all filled entries; at most one can match
   always_comb begin
      index_in = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = (COUNT_W'(i) < count_ff) && (session_ff[i] == session_id_ff);
         if (match[i]) begin
            index_in = index_in | INDEX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         index_ff <= index_in;
         hit_ff   <= |match;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         stored_ff <= highest_mem[index_ff];
      end
   end

   // write back
   always_comb begin
      is_update  = (command_ff == CMD_UPDATE);
      raise      = hit_ff && is_update && (version_ff > stored_ff);
      append     = !hit_ff && is_update && (count_ff < COUNT_W'(TABLE_DEPTH));
      mem_we     = cmd.write && (raise || append);
      wr_addr    = hit_ff ? index_ff : count_ff[INDEX_W-1:0];
      count_in   = append ? count_ff + COUNT_W'(1) : count_ff;
      if (hit_ff) begin
         highest_in = raise ? version_ff : stored_ff;
      end else begin
         highest_in = append ? version_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         highest_mem[wr_addr] <= version_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && append) begin
         session_ff[count_ff[INDEX_W-1:0]] <= session_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.write) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         highest_ff <= highest_in;
         hit_out_ff <= hit_ff;
         status_ff  <= (!hit_ff && is_update && !append) ? STATUS_FULL : STATUS_OK;
         active_ff  <= ACTIVE_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peak_version    = highest_ff;
   assign rsp_hit             = hit_out_ff;
   assign rsp_status          = status_ff;
   assign rsp_active_sessions = active_ff;

endmodule

// ----- rtl/core/session_version_view_table_top.sv -----
// Top level of the session version view table.
//
// Request channel (req_*): command (0 update, 1 query), session id and the
// seen version. Response channel (rsp_*): highest stored version, hit flag,
// status (1 = table full, new session dropped) and the number of active
// sessions. Both channels use valid/stall; a transaction moves on a clock
// edge with valid high and stall low.
// One request is in flight at a time. It passes capture, a parallel compare
// across all session entries, a registered read of the version memory and a
// write-back into the output register, which makes the response valid; a new
// request is taken only once the sequencer is back in idle. The write-back
// step waits while a previous response sits stalled in the output register;
// the request side stays stalled for that whole time.
// Synchronous reset empties the table (entry count to zero), drops any
// pending response and returns the sequencer to idle; no clearing pass is
// needed since only entries below the count can ever match.
module session_version_view_table_top import svvt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [SESSION_W-1:0] req_session_id,
   input  logic [VERSION_W-1:0] req_seen_version,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VERSION_W-1:0] rsp_peak_version,
   output logic                 rsp_hit,
   output logic                 rsp_status,
   output logic [ACTIVE_W-1:0]  rsp_active_sessions
);

   svvt_cmd_type cmd;
   svvt_sts_type sts;

   svvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   svvt_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_command         (req_command),
      .req_session_id      (req_session_id),
      .req_seen_version    (req_seen_version),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_peak_version    (rsp_peak_version),
      .rsp_hit             (rsp_hit),
      .rsp_status          (rsp_status),
      .rsp_active_sessions (rsp_active_sessions)
   );

   // a dropped session reports nothing stored
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (!rsp_hit && rsp_peak_version == '0))
      else $error("full-table drop returned a hit or a version");

   // a hit never reports a full table
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_status == STATUS_OK))
      else $error("hit flagged as full-table drop");

   // one transaction in flight: the request side closes right after a take
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request taken while one is in flight");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the session version view table: directed and random requests checked against a predictor.
module tb;
   import svvt_pkg::*;

   localparam int MAX_CYCLES   = 200000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int LONG_HOLD    = 150;

   typedef struct {
      logic [VERSION_W-1:0] highest;
      logic                 hit;
      logic                 status;
      logic [ACTIVE_W-1:0]  active;
   } view_result_type;

   class version_scoreboard;
      logic [SESSION_W-1:0] sess_id   [TABLE_DEPTH];
      logic [VERSION_W-1:0] sess_high [TABLE_DEPTH];
      int unsigned          used    = 0;
      view_result_type      due [$];
      int                   errors  = 0;
      int                   checked = 0;
      int                   hits    = 0;
      int                   drops   = 0;
      int                   queries = 0;

      function int find_session(logic [SESSION_W-1:0] sid);
         for (int i = 0; i < used; i++)
            if (sess_id[i] == sid) return i;
         return -1;
      endfunction

      function void note_request(logic cmd, logic [SESSION_W-1:0] sid,
                                 logic [VERSION_W-1:0] ver);
         int              idx;
         view_result_type r;
         idx = find_session(sid);
         r.highest = '0;
         r.hit     = 1'b0;
         r.status  = STATUS_OK;
         if (cmd == CMD_QUERY) queries++;
         if (idx >= 0) begin
            r.hit = 1'b1;
            hits++;
            if (cmd == CMD_UPDATE && ver > sess_high[idx]) sess_high[idx] = ver;
            r.highest = sess_high[idx];
         end else if (cmd == CMD_UPDATE) begin
            if (used < TABLE_DEPTH) begin
               sess_id[used]   = sid;
               sess_high[used] = ver;
               used++;
               r.highest = ver;
            end else begin
               // table full: new session is dropped
               r.status = STATUS_FULL;
               drops++;
            end
         end
         r.active = ACTIVE_W'(used);
         due.push_back(r);
      endfunction

      function void check_result(logic [VERSION_W-1:0] highest, logic hit, logic status,
                                 logic [ACTIVE_W-1:0] active);
         view_result_type e;
         if (due.size() == 0) begin
            $error("unexpected response: peak_version %h hit %b status %b active_sessions %0d",
                   highest, hit, status, active);
            errors++;
            return;
         end
         e = due.pop_front();
         checked++;
         if (highest !== e.highest) begin
            $error("peak_version: expected %h, got %h", e.highest, highest);
            errors++;
         end
         if (hit !== e.hit) begin
            $error("hit: expected %b, got %b", e.hit, hit);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %b, got %b", e.status, status);
            errors++;
         end
         if (active !== e.active) begin
            $error("active_sessions: expected %0d, got %0d", e.active, active);
            errors++;
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic                 req_command      = CMD_UPDATE;
   logic [SESSION_W-1:0] req_session_id   = '0;
   logic [VERSION_W-1:0] req_seen_version = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [VERSION_W-1:0] rsp_peak_version;
   logic                 rsp_hit;
   logic                 rsp_status;
   logic [ACTIVE_W-1:0]  rsp_active_sessions;

   version_scoreboard    sb = new;
   logic [SESSION_W-1:0] id_pool [$];
   bit                   tx_calm = 1'b0;
   int                   sent = 0;
   int                   cycle_count = 0;

   session_version_view_table_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_session_id      (req_session_id),
      .req_seen_version    (req_seen_version),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_peak_version    (rsp_peak_version),
      .rsp_hit             (rsp_hit),
      .rsp_status          (rsp_status),
      .rsp_active_sessions (rsp_active_sessions)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Timeout after %0d cycles with %0d responses pending",
                  cycle_count, sb.due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_request(logic cmd, logic [SESSION_W-1:0] sid,
                               logic [VERSION_W-1:0] ver);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_session_id   <= sid;
      req_seen_version <= ver;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(cmd, sid, ver);
      sent++;
   endtask

   // Half the time reuse a live table entry, else an old id or a fresh one.
   function automatic logic [SESSION_W-1:0] pick_session();
      logic [SESSION_W-1:0] sid;
      int                   roll;
      roll = $urandom_range(0, 99);
      if (sb.used > 0 && roll < 50) begin
         sid = sb.sess_id[$urandom_range(0, sb.used - 1)];
      end else if (id_pool.size() > 0 && roll < 75) begin
         sid = id_pool[$urandom_range(0, id_pool.size() - 1)];
      end else begin
         case ($urandom_range(0, 9))
            0:       sid = '0;
            1:       sid = '1;
            default: sid = $urandom;
         endcase
         id_pool.push_back(sid);
      end
      return sid;
   endfunction

   // Versions around the stored one so raises, keeps and ties all happen.
   function automatic logic [VERSION_W-1:0] pick_version(logic [SESSION_W-1:0] sid);
      int                   idx;
      logic [VERSION_W-1:0] base;
      logic [VERSION_W-1:0] delta;
      idx   = sb.find_session(sid);
      base  = (idx >= 0) ? sb.sess_high[idx] : '0;
      delta = VERSION_W'($urandom_range(1, 1000));
      case ($urandom_range(0, 7))
         0:       return base;
         1, 2:    return base + delta;
         3:       return base - delta;
         4:       return '1;
         5:       return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Response side: random stalls, calm stretches and one long hold-off.
   initial begin
      int hold;
      bit long_done;
      bit rx_calm;
      long_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         rx_calm = ((sb.checked / 130) % 4 == 2);
         if (!long_done && sb.checked >= 400) begin
            hold      = LONG_HOLD;
            long_done = 1'b1;
         end else begin
            hold = rx_calm ? 0 : $urandom_range(0, 5);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_peak_version, rsp_hit, rsp_status, rsp_active_sessions);
      end
   end

   initial begin
      logic                 cmd;
      logic [SESSION_W-1:0] sid;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, raise/keep/tie, query leaves state alone
      send_request(CMD_QUERY,  32'h0000_0000, '1);
      send_request(CMD_UPDATE, 32'h0000_0000, '0);
      send_request(CMD_UPDATE, 32'hFFFF_FFFF, '1);
      send_request(CMD_UPDATE, 32'hFFFF_FFFF, 64'd5);
      send_request(CMD_UPDATE, 32'h0000_0000, '0);
      send_request(CMD_UPDATE, 32'h0000_0000, 64'd1);
      send_request(CMD_QUERY,  32'h0000_0000, '1);
      send_request(CMD_QUERY,  32'h0000_0000, '0);
      send_request(CMD_QUERY,  32'hFFFF_FFFF, '0);
      send_request(CMD_QUERY,  32'h5555_AAAA, '0);
      send_request(CMD_UPDATE, 32'hAAAA_5555, 64'h5555_5555_5555_5555);
      send_request(CMD_UPDATE, 32'h5555_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CMD_UPDATE, 32'hAAAA_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(CMD_UPDATE, 32'h8000_0000, 64'h8000_0000_0000_0000);
      send_request(CMD_UPDATE, 32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      send_request(CMD_QUERY,  32'h8000_0000, 64'h1234_5678_9ABC_DEF0);
      send_request(CMD_QUERY,  32'h5555_AAAA, '0);

      // random: the table fills along the way, then new sessions get dropped
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         tx_calm = ((n / 150) % 4 == 1);
         if (n == 1000) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.due.size() != 0);
         end
         cmd = ($urandom_range(0, 99) < 30) ? CMD_QUERY : CMD_UPDATE;
         sid = pick_session();
         send_request(cmd, sid, pick_version(sid));
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due.size() != 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests (%0d queries); %0d responses checked, %0d hits.",
               sent, sb.queries, sb.checked, sb.hits);
      $display("Table reached %0d of %0d sessions; %0d new sessions dropped while full.",
               sb.used, TABLE_DEPTH, sb.drops);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- session_version_view_table_top.f -----
rtl/core/svvt_pkg.sv
rtl/core/svvt_ctrl.sv
rtl/core/svvt_datapath.sv
rtl/core/session_version_view_table_top.sv
tb/tb.sv
